@@ sv/flex_level_vote_gesture_macros.svh @@
// assertion helpers for the flex level vote block
`ifndef FLEX_LEVEL_VOTE_GESTURE_MACROS_SVH
`define FLEX_LEVEL_VOTE_GESTURE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FLVG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flvg assertion failed");

// next-cycle implication, checked out of reset
`define FLVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flvg assertion failed");

`endif

@@ sv/flvg_pkg.sv @@
package flvg_pkg;

    localparam int FINGERS     = 5;
    localparam int SAMPLE_BITS = 10;
    localparam int CFG_BITS    = 2 * SAMPLE_BITS;
    localparam int CODE_BITS   = 2 * FINGERS;
    localparam int GEST_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_BITS-1:0]    thr_t;
    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [1:0]             level_t;
    typedef logic [GEST_BITS-1:0]   gesture_t;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_THUMB  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INDEX  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RING   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PINKY  = 3'd4;

    localparam thr_t THR_RESET [FINGERS] = '{
        20'd614600, 20'd717100, 20'd717100, 20'd717100, 20'd768500
    };

    localparam level_t LVL_LOW  = 2'd0;
    localparam level_t LVL_MID  = 2'd1;
    localparam level_t LVL_HIGH = 2'd2;

    localparam code_t CODE_HELLO = 10'b0000000000;
    localparam code_t CODE_OKAY  = 10'b0101000000;
    localparam code_t CODE_LOVE  = 10'b0000101000;
    localparam code_t CODE_YES_A = 10'b0010101010;
    localparam code_t CODE_YES_B = 10'b0110101010;

    localparam gesture_t G_UNKNOWN = 3'd0;
    localparam gesture_t G_HELLO   = 3'd1;
    localparam gesture_t G_OKAY    = 3'd2;
    localparam gesture_t G_LOVE    = 3'd3;
    localparam gesture_t G_YES     = 3'd4;

    typedef struct packed {
        logic clear;
        logic acc;
    } vote_ctrl_t;

    function automatic level_t quantize(input sample_t s, input thr_t thr);
        sample_t mid;
        sample_t high;
        mid  = thr[SAMPLE_BITS-1:0];
        high = thr[CFG_BITS-1:SAMPLE_BITS];
        if (s < mid)
            return LVL_LOW;
        else if (s < high)
            return LVL_MID;
        else
            return LVL_HIGH;
    endfunction

    function automatic gesture_t match_gesture(input code_t code);
        case (code)
            CODE_HELLO: return G_HELLO;
            CODE_OKAY:  return G_OKAY;
            CODE_LOVE:  return G_LOVE;
            CODE_YES_A: return G_YES;
            CODE_YES_B: return G_YES;
            default:    return G_UNKNOWN;
        endcase
    endfunction

endpackage

@@ sv/flex_level_vote_gesture.sv @@
// flex level vote gesture
// input channel (in_valid/in_ready) carries five 10-bit bend samples, one per
// finger; each is quantised to a level 0..2 against that finger's mid/high
// thresholds and the packed levels are written to a small history memory.
// every WINDOW-th transaction closes the window: the history is read back one
// entry a cycle, per-finger tallies pick the majority level (tie to the lower
// level) and one result (level_code, gesture) is posted on the output channel.
// other transactions give no result.
// throughput: one item per cycle while the window fills; the closing item
// holds in_ready low through the read (one memory read per entry), a landing
// state for the last read to land, and until the result is posted.
// from the closing transaction, out_valid rises after ST_READ, ST_LAND and ST_DONE.
// the result sits in an output register; if the receiver stalls, new samples
// are still taken, only the next window close waits for the register to free.
// config port: write cfg_data to the threshold register cfg_index (0 thumb ..
// 4 pinky), mid in bits 9:0, high in 19:10; always ready, other indexes
// ignored. write only while idle.
// reset clears the window count, output valid and thresholds to defaults;
// history contents need no clearing.
`include "flex_level_vote_gesture_macros.svh"

module flex_level_vote_gesture #(
    parameter int WINDOW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  flvg_pkg::sample_t             thumb_sample,
    input  flvg_pkg::sample_t             index_sample,
    input  flvg_pkg::sample_t             middle_sample,
    input  flvg_pkg::sample_t             ring_sample,
    input  flvg_pkg::sample_t             pinky_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output flvg_pkg::code_t               level_code,
    output flvg_pkg::gesture_t            gesture,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [flvg_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  flvg_pkg::thr_t                cfg_data
);
    import flvg_pkg::*;

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [AW-1:0] LAST = AW'(WINDOW - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LAND = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] sample_count_reg, sample_count_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          acc_reg;
    thr_t          thr_reg [FINGERS];

    logic          out_valid_reg, out_valid_next;
    code_t         level_code_reg;
    gesture_t      gesture_reg;

    logic          in_fire;
    logic          rd_en;
    logic          load_out;
    code_t         entry;
    code_t         rd_data;
    code_t         vote_code;
    vote_ctrl_t    vote_ctrl;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FINGERS; f++)
            begin
                thr_reg[f] <= THR_RESET[f];
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THUMB:  thr_reg[0] <= cfg_data;
                REG_INDEX:  thr_reg[1] <= cfg_data;
                REG_MIDDLE: thr_reg[2] <= cfg_data;
                REG_RING:   thr_reg[3] <= cfg_data;
                REG_PINKY:  thr_reg[4] <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign entry = {quantize(thumb_sample,  thr_reg[0]),
                    quantize(index_sample,  thr_reg[1]),
                    quantize(middle_sample, thr_reg[2]),
                    quantize(ring_sample,   thr_reg[3]),
                    quantize(pinky_sample,  thr_reg[4])};

    always_comb
    begin
        state_next        = state_reg;
        sample_count_next = sample_count_reg;
        rd_addr_next      = rd_addr_reg;
        rd_en             = 1'b0;
        load_out          = 1'b0;
        vote_ctrl.clear   = 1'b0;
        vote_ctrl.acc     = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (sample_count_reg == LAST)
                    begin
                        sample_count_next = '0;
                        rd_addr_next      = '0;
                        vote_ctrl.clear   = 1'b1;
                        state_next        = ST_READ;
                    end
                    else
                    begin
                        sample_count_next = sample_count_reg + AW'(1);
                    end
                end
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (rd_addr_reg == LAST)
                begin
                    state_next = ST_LAND;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end
            ST_LAND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_count_reg <= '0;
            rd_addr_reg      <= '0;
            acc_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            rd_addr_reg      <= rd_addr_next;
            acc_reg          <= rd_en;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            level_code_reg <= vote_code;
            gesture_reg    <= match_gesture(vote_code);
        end
    end

    flvg_hist_mem #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_hist_mem (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (sample_count_reg),
        .wr_data (entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    flvg_vote #(
        .WINDOW (WINDOW)
    ) u_vote (
        .clk   (clk),
        .ctrl  (vote_ctrl),
        .entry (rd_data),
        .code  (vote_code)
    );

    assign out_valid  = out_valid_reg;
    assign level_code = level_code_reg;
    assign gesture    = gesture_reg;

    `FLVG_ASSERT_NOW(a_count_in_window, 1'b1, sample_count_reg <= LAST)
    `FLVG_ASSERT_NEXT(a_close_starts_read, in_fire && (sample_count_reg == LAST),
                      state_reg == ST_READ)
    `FLVG_ASSERT_NOW(a_result_after_vote, $rose(out_valid_reg), $past(state_reg == ST_DONE))
    `FLVG_ASSERT_NOW(a_yes_code, out_valid_reg && (gesture_reg == G_YES),
                     (level_code_reg == CODE_YES_A) || (level_code_reg == CODE_YES_B))

endmodule

@@ sv/flvg_hist_mem.sv @@
module flvg_hist_mem #(
    parameter int DEPTH = 5,
    parameter int AW    = 3
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  flvg_pkg::code_t       wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output flvg_pkg::code_t       rd_data
);
    import flvg_pkg::*;

    code_t mem [DEPTH];
    code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/flvg_vote.sv @@
module flvg_vote #(
    parameter int WINDOW = 5
) (
    input  logic                  clk,
    input  flvg_pkg::vote_ctrl_t  ctrl,
    input  flvg_pkg::code_t       entry,
    output flvg_pkg::code_t       code
);
    import flvg_pkg::*;

    localparam int CNTW = $clog2(WINDOW + 1);

    logic [CNTW-1:0] cnt0_reg [FINGERS];
    logic [CNTW-1:0] cnt1_reg [FINGERS];
    logic [CNTW-1:0] cnt2_reg [FINGERS];

    // per-finger level tallies over the window
    always_ff @(posedge clk)
    begin
        for (int f = 0; f < FINGERS; f++)
        begin
            if (ctrl.clear)
            begin
                cnt0_reg[f] <= '0;
                cnt1_reg[f] <= '0;
                cnt2_reg[f] <= '0;
            end
            else if (ctrl.acc)
            begin
                case (entry[2*(FINGERS-1-f) +: 2])
                    LVL_LOW:  cnt0_reg[f] <= cnt0_reg[f] + CNTW'(1);
                    LVL_MID:  cnt1_reg[f] <= cnt1_reg[f] + CNTW'(1);
                    LVL_HIGH: cnt2_reg[f] <= cnt2_reg[f] + CNTW'(1);
                    default:  ;
                endcase
            end
        end
    end

    // majority, tie to the lower level
    always_comb
    begin
        logic [CNTW-1:0] best_cnt;
        level_t          best;
        code = '0;
        for (int f = 0; f < FINGERS; f++)
        begin
            best     = LVL_LOW;
            best_cnt = cnt0_reg[f];
            if (cnt1_reg[f] > best_cnt)
            begin
                best     = LVL_MID;
                best_cnt = cnt1_reg[f];
            end
            if (cnt2_reg[f] > best_cnt)
            begin
                best = LVL_HIGH;
            end
            code[2*(FINGERS-1-f) +: 2] = best;
        end
    end

endmodule
